@@ design/dual_encoder_pd_speed_loop_macros.svh @@
// assertion helpers shared by the speed loop rtl
`ifndef DUAL_ENCODER_PD_SPEED_LOOP_MACROS_SVH
`define DUAL_ENCODER_PD_SPEED_LOOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define DEPSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define DEPSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEPSL_ASSERT_IMPL(lbl, ante, cons, msg)
`define DEPSL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/depsl_pkg.sv @@
package depsl_pkg;

  localparam int DEPSL_LOG_DEPTH  = 128;
  localparam int DEPSL_COUNT_BITS = 16;
  // one log row holds both channels, 16 bits each
  localparam int DEPSL_LOG_ROW_W  = 32;

  typedef enum logic [1:0] {
    OP_EDGE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_TARGET = 2'd2,
    OP_READ   = 2'd3
  } depsl_op_t;

  typedef enum logic [1:0] {
    REG_KP           = 2'd0,
    REG_KD           = 2'd1,
    REG_RUN_LENGTH   = 2'd2,
    REG_COUNT_INVERT = 2'd3
  } depsl_reg_t;

  typedef struct packed {
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic       running;
    logic       run_done;
  } depsl_res_t;

endpackage

@@ design/depsl_in_if.sv @@
interface depsl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       channel;
  logic       phase_b;
  logic [7:0] target_value;
  logic [6:0] entry_index;

  modport source (
    output valid, opcode, channel, phase_b, target_value, entry_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, phase_b, target_value, entry_index,
    output ready
  );
endinterface

@@ design/depsl_out_if.sv @@
interface depsl_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         drive_a;
  logic [7:0]         drive_b;
  logic               running;
  logic               run_done;
  logic signed [15:0] log_value;

  modport source (
    output valid, drive_a, drive_b, running, run_done, log_value,
    input  ready
  );
  modport sink (
    input  valid, drive_a, drive_b, running, run_done, log_value,
    output ready
  );
endinterface

@@ design/depsl_log_ram.sv @@
module depsl_log_ram import depsl_pkg::*; #(
  parameter int  DEPTH  = DEPSL_LOG_DEPTH,
  parameter int  WIDTH  = DEPSL_LOG_ROW_W,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/depsl_core.sv @@
module depsl_core import depsl_pkg::*; #(
  parameter int  LOG_DEPTH  = DEPSL_LOG_DEPTH,
  parameter int  COUNT_BITS = DEPSL_COUNT_BITS,
  localparam int ADDR_W     = $clog2(LOG_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  depsl_op_t                  op,
  input  logic                       channel,
  input  logic                       phase_b,
  input  logic [7:0]                 target_value,
  input  logic signed [7:0]          kp,
  input  logic signed [7:0]          kd,
  input  logic [7:0]                 run_length,
  input  logic [1:0]                 count_invert,
  output depsl_res_t                 res,
  output logic                       log_we,
  output logic [ADDR_W-1:0]          log_waddr,
  output logic [DEPSL_LOG_ROW_W-1:0] log_wdata
);

  localparam int ERR_W = COUNT_BITS + 2;
  localparam int CHG_W = ERR_W + 1;
  localparam int SUM_W = CHG_W + 10;
  localparam int LIM_W = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic signed [COUNT_BITS-1:0] cnt_r [2];
  logic signed [COUNT_BITS-1:0] cnt_nxt [2];
  logic signed [ERR_W-1:0]      perr_r [2];
  logic signed [ERR_W-1:0]      perr_nxt [2];
  logic [7:0]                   drv_r [2];
  logic [7:0]                   drv_nxt [2];
  logic [7:0]                   tgt_r, tgt_nxt;
  logic                         first_r, first_nxt;
  logic                         run_r, run_nxt;
  logic [ADDR_W-1:0]            pidx_r, pidx_nxt;
  logic                         done;

  logic signed [ERR_W-1:0]      err [2];
  logic signed [CHG_W-1:0]      chg [2];
  logic signed [ERR_W+7:0]      prod_p [2];
  logic signed [CHG_W+7:0]      prod_d [2];
  logic signed [SUM_W-1:0]      sum [2];
  logic [7:0]                   drv_pd [2];
  logic signed [31:0]           cnt32 [2];
  logic [15:0]                  log16 [2];
  logic signed [COUNT_BITS-1:0] cnt_cur, cnt_step;
  logic                         up;
  logic [LIM_W-1:0]             limit, pidx_inc;

  // per-channel pd update and log saturation
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      err[c]    = ERR_W'($signed({1'b0, tgt_r})) - ERR_W'(cnt_r[c]);
      chg[c]    = CHG_W'(err[c]) - CHG_W'(perr_r[c]);
      prod_p[c] = (ERR_W+8)'(kp) * (ERR_W+8)'(err[c]);
      prod_d[c] = (CHG_W+8)'(kd) * (CHG_W+8)'(chg[c]);
      sum[c]    = SUM_W'($signed({1'b0, drv_r[c]})) + SUM_W'(prod_p[c])
                + SUM_W'(prod_d[c]);
      if (sum[c][SUM_W-1]) begin
        drv_pd[c] = 8'd0;
      end else if (sum[c] > SUM_W'(255)) begin
        drv_pd[c] = 8'd255;
      end else begin
        drv_pd[c] = sum[c][7:0];
      end
      cnt32[c] = 32'(cnt_r[c]);
      if (cnt32[c] > 32'sd32767) begin
        log16[c] = 16'h7fff;
      end else if (cnt32[c] < -32'sd32768) begin
        log16[c] = 16'h8000;
      end else begin
        log16[c] = cnt32[c][15:0];
      end
    end
  end

  // saturating edge step
  always_comb begin
    up      = phase_b ^ count_invert[channel];
    cnt_cur = cnt_r[channel];
    if (up) begin
      cnt_step = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    end else begin
      cnt_step = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_cur - COUNT_BITS'(1);
    end
  end

  always_comb begin
    limit    = (LIM_W'(run_length) > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH)
                                                          : LIM_W'(run_length);
    pidx_inc = LIM_W'(pidx_r) + LIM_W'(1);
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    perr_nxt  = perr_r;
    drv_nxt   = drv_r;
    tgt_nxt   = tgt_r;
    first_nxt = first_r;
    run_nxt   = run_r;
    pidx_nxt  = pidx_r;
    done      = 1'b0;
    log_we    = 1'b0;
    log_waddr = pidx_r;
    log_wdata = {log16[1], log16[0]};
    if (accept) begin
      unique case (op)
        OP_EDGE: begin
          cnt_nxt[channel] = cnt_step;
        end
        OP_TICK: begin
          if (run_r) begin
            cnt_nxt[0] = '0;
            cnt_nxt[1] = '0;
            if (first_r) begin
              first_nxt = 1'b0;
            end else begin
              perr_nxt = err;
              drv_nxt  = drv_pd;
              log_we   = 1'b1;
              if (pidx_inc >= limit) begin
                run_nxt    = 1'b0;
                first_nxt  = 1'b0;
                drv_nxt[0] = 8'd0;
                drv_nxt[1] = 8'd0;
                pidx_nxt   = '0;
                done       = 1'b1;
              end else begin
                pidx_nxt = pidx_inc[ADDR_W-1:0];
              end
            end
          end
        end
        OP_TARGET: begin
          tgt_nxt    = target_value;
          drv_nxt[0] = target_value;
          drv_nxt[1] = target_value;
          first_nxt  = 1'b1;
          run_nxt    = 1'b1;
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
      perr_r[0] <= '0;
      perr_r[1] <= '0;
      drv_r[0]  <= '0;
      drv_r[1]  <= '0;
      tgt_r     <= '0;
      first_r   <= 1'b0;
      run_r     <= 1'b0;
      pidx_r    <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      perr_r  <= perr_nxt;
      drv_r   <= drv_nxt;
      tgt_r   <= tgt_nxt;
      first_r <= first_nxt;
      run_r   <= run_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  always_comb begin
    res.drive_a  = drv_nxt[0];
    res.drive_b  = drv_nxt[1];
    res.running  = run_nxt;
    res.run_done = done;
  end

`include "dual_encoder_pd_speed_loop_macros.svh"

  `DEPSL_ASSERT_IMPL(a_first_needs_run, first_r, run_r, "first-tick flag without a run")
  `DEPSL_ASSERT_IMPL(a_idle_pidx_zero, !run_r, pidx_r == '0, "period index left over when idle")
  `DEPSL_ASSERT_NEXT(a_edge_keeps_run, accept && op == OP_EDGE, run_r == $past(run_r) && first_r == $past(first_r), "edge disturbed run control")

endmodule

@@ design/dual_encoder_pd_speed_loop.sv @@
// two-channel pd speed loop: encoder edges, period ticks, target commands and log reads
// arrive as one word each on in_ch and each gives exactly one result word on out_ch;
// one word is taken every cycle unless out_ch back-pressure stalls the pipeline, and a
// result passes through stage one (the registered read of the count log) and then
// the output register; the per-channel state update finishes in the cycle of acceptance,
// so a tick may follow an edge or another tick directly; the count log sits in a single
// synchronous ram, one row per period holding both channels, and needs no clearing
// after reset, but entries not yet written by a run read back as unknown
module dual_encoder_pd_speed_loop import depsl_pkg::*; #(
  parameter int LOG_DEPTH  = DEPSL_LOG_DEPTH,
  parameter int COUNT_BITS = DEPSL_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  depsl_in_if.sink    in_ch,
  depsl_out_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int ADDR_W = $clog2(LOG_DEPTH);

  // configuration registers
  logic signed [7:0] kp_r, kd_r;
  logic [7:0]        run_length_r;
  logic [1:0]        count_invert_r;

  // handshake and stage control
  logic accept;
  logic s1_adv;
  logic rd_ok;

  // core outputs
  depsl_res_t                 core_res;
  logic                       log_we;
  logic [ADDR_W-1:0]          log_waddr;
  logic [DEPSL_LOG_ROW_W-1:0] log_wdata;
  logic [DEPSL_LOG_ROW_W-1:0] log_rdata;

  // stage one: waits on the log ram read
  logic       s1_valid_r;
  depsl_res_t s1_res_r;
  logic       s1_ch_r;
  logic       s1_rd_r;

  // output register
  logic        o_valid_r;
  depsl_res_t  o_res_r;
  logic [15:0] o_log_r;
  logic [15:0] log_sel;

  // config writes must be issued only while the loop is quiet; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r           <= '0;
      kd_r           <= '0;
      run_length_r   <= 8'd100;
      count_invert_r <= 2'd2;
    end else if (cfg_wr_en) begin
      unique case (depsl_reg_t'(cfg_index))
        REG_KP:           kp_r           <= cfg_wdata;
        REG_KD:           kd_r           <= cfg_wdata;
        REG_RUN_LENGTH:   run_length_r   <= cfg_wdata;
        REG_COUNT_INVERT: count_invert_r <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // stage one moves on when the output register is free or being drained;
  // a new word is taken whenever stage one is empty or moving on
  assign s1_adv      = s1_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !o_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // log reads beyond the depth return zero
  assign rd_ok = 32'(in_ch.entry_index) < 32'(LOG_DEPTH);

  depsl_core #(
    .LOG_DEPTH  (LOG_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (depsl_op_t'(in_ch.opcode)),
    .channel      (in_ch.channel),
    .phase_b      (in_ch.phase_b),
    .target_value (in_ch.target_value),
    .kp           (kp_r),
    .kd           (kd_r),
    .run_length   (run_length_r),
    .count_invert (count_invert_r),
    .res          (core_res),
    .log_we       (log_we),
    .log_waddr    (log_waddr),
    .log_wdata    (log_wdata)
  );

  // a read taken in the cycle after the tick that wrote the same row sees the new data
  depsl_log_ram #(
    .DEPTH (LOG_DEPTH),
    .WIDTH (DEPSL_LOG_ROW_W)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (log_we),
    .wr_addr (log_waddr),
    .wr_data (log_wdata),
    .rd_en   (accept && (depsl_op_t'(in_ch.opcode) == OP_READ) && rd_ok),
    .rd_addr (ADDR_W'(in_ch.entry_index)),
    .rd_data (log_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // channel pick from the log row
  always_comb begin
    if (s1_rd_r) begin
      log_sel = s1_ch_r ? log_rdata[31:16] : log_rdata[15:0];
    end else begin
      log_sel = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= core_res;
      s1_ch_r  <= in_ch.channel;
      s1_rd_r  <= (depsl_op_t'(in_ch.opcode) == OP_READ) && rd_ok;
    end
    if (s1_adv) begin
      o_res_r <= s1_res_r;
      o_log_r <= log_sel;
    end
  end

  assign out_ch.valid     = o_valid_r;
  assign out_ch.drive_a   = o_res_r.drive_a;
  assign out_ch.drive_b   = o_res_r.drive_b;
  assign out_ch.running   = o_res_r.running;
  assign out_ch.run_done  = o_res_r.run_done;
  assign out_ch.log_value = o_log_r;

`include "dual_encoder_pd_speed_loop_macros.svh"

  `DEPSL_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_res_r), "stage one lost a word")
  `DEPSL_ASSERT_IMPL(a_done_stops, o_valid_r && o_res_r.run_done, !o_res_r.running && o_res_r.drive_a == '0 && o_res_r.drive_b == '0, "run end left drives on")
  `DEPSL_ASSERT_NEXT(a_log_zero, s1_adv && !s1_rd_r, out_ch.log_value == '0, "log value on a non-read word")

endmodule
